>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ASSERT_ON_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent check on the block's own clock and reset.
`define ASSERT_DEFAULT(label, prop, msg) \
  `ASSERT_ON_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> hdl/tpc_pkg.sv
`timescale 1ns / 1ps

package tpc_pkg;

  // Field widths
  localparam int unsigned TEMP_W  = 12;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned ERR_W   = 14;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned PROD_W  = 39;
  localparam int unsigned STATE_W = 48;
  localparam int unsigned SP_W    = 8;
  localparam int unsigned BAND_W  = 11;
  localparam int unsigned LIMIT_W = 30;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTEG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_M      = 3'd5;

  // Register reset values
  localparam logic [SP_W-1:0]    RST_SETPOINT    = 8'd0;
  localparam logic [BAND_W-1:0]  RST_BAND        = 11'd50;
  localparam logic [LIMIT_W-1:0] RST_MAX_INTEG   = 30'd13107200;
  localparam logic [GAIN_W-1:0]  RST_GAIN_P      = 24'd196608;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I      = 24'd655;
  localparam logic [GAIN_W-1:0]  RST_GAIN_M      = 24'd32768;

  // Duty scaling: total carries 16 fraction bits in tenths, so percent = total / 655360.
  localparam logic signed [STATE_W-1:0] DUTY_OVER = 48'sd66191360; // 101 percent
  localparam logic [DUTY_W-1:0]         DUTY_MAX  = 7'd100;
  localparam logic [7:0]                DIV10_MUL = 8'd205;        // exact below 1029

  typedef struct packed {
    logic [SP_W-1:0]    setpoint;
    logic [BAND_W-1:0]  band;
    logic [LIMIT_W-1:0] max_integral;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_m;
  } cfg_t;

  // Truncated percent, clamped to 0..100.
  function automatic logic [DUTY_W-1:0] duty_from_total(input logic signed [STATE_W-1:0] total);
    logic [9:0]  whole;
    logic [17:0] scaled;
    whole  = total[25:16];
    scaled = 18'(whole) * 18'(DIV10_MUL);
    if (total <= 0) begin
      return '0;
    end else if (total >= DUTY_OVER) begin
      return DUTY_MAX;
    end else begin
      return scaled[17:11];
    end
  endfunction

endpackage

>>> hdl/tpc_cfg_regs.sv
`timescale 1ns / 1ps

module tpc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output tpc_pkg::cfg_t                     cfg_o
);
  import tpc_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint     <= RST_SETPOINT;
      cfg_q.band         <= RST_BAND;
      cfg_q.max_integral <= RST_MAX_INTEG;
      cfg_q.gain_p       <= RST_GAIN_P;
      cfg_q.gain_i       <= RST_GAIN_I;
      cfg_q.gain_m       <= RST_GAIN_M;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // keep the low bits of the data, drop writes to unknown indexes
      case (cfg_index_i)
        REG_SETPOINT:  cfg_q.setpoint     <= cfg_data_i[SP_W-1:0];
        REG_BAND:      cfg_q.band         <= cfg_data_i[BAND_W-1:0];
        REG_MAX_INTEG: cfg_q.max_integral <= cfg_data_i[LIMIT_W-1:0];
        REG_GAIN_P:    cfg_q.gain_p       <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I:    cfg_q.gain_i       <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_M:    cfg_q.gain_m       <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/temperature_pi_controller.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------
// in       | in        | in_valid_i, in_stall_o | temperature_tenths_i
// out      | out       | out_valid_o,out_stall_i| duty_percent_o, measured_temp_o
// cfg      | in        | cfg_valid_i,cfg_ready_o| cfg_index_i, cfg_data_i
//
// One sample per cycle when the output does not stall; the result becomes valid
// after the input register, then the product, total and result registers.
// Integrator and history line update as a sample leaves the product register.
// Reset clears the integrator, the history line and all stage valids.
// Each stage advances when the stage after it is empty or moving, so a stalled
// output still lets up to three more samples enter before in_stall_o rises.
`include "assert_macros.svh"

module temperature_pi_controller #(
  parameter int unsigned HISTORY_DEPTH = 5
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [tpc_pkg::TEMP_W-1:0]     temperature_tenths_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [tpc_pkg::DUTY_W-1:0]            duty_percent_o,
  output logic signed [tpc_pkg::TEMP_W-1:0]     measured_temp_o
);
  import tpc_pkg::*;

  cfg_t cfg;

  tpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Stage valids and enables
  logic s0_valid_q, s1_valid_q, s2_valid_q, out_valid_q;
  logic en0, en1, en2, en3;
  logic s1_fire;

  assign en3     = !out_valid_q || !out_stall_i;
  assign en2     = !s2_valid_q || en3;
  assign en1     = !s1_valid_q || en2;
  assign en0     = !s0_valid_q || en1;
  assign s1_fire = s1_valid_q && en2;

  assign in_stall_o  = !en0;
  assign out_valid_o = out_valid_q;

  // Stage 0: input register
  logic signed [TEMP_W-1:0] s0_temp_q;

  // Stage 0 -> 1: error and the three products
  logic [TEMP_W-1:0]         sp_tenths;
  logic signed [ERR_W-1:0]   err;
  logic signed [PROD_W-1:0]  prod_p, prod_i, prod_m;
  logic                      err_neg, in_band;

  assign sp_tenths = {1'b0, cfg.setpoint, 3'b000} + {3'b000, cfg.setpoint, 1'b0};
  assign err       = $signed({2'b00, sp_tenths})
                   - $signed({{(ERR_W-TEMP_W){s0_temp_q[TEMP_W-1]}}, s0_temp_q});
  assign err_neg   = err[ERR_W-1];
  assign in_band   = !err_neg && (err < $signed({{(ERR_W-BAND_W){1'b0}}, cfg.band}));
  assign prod_p    = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.gain_p}) * PROD_W'(err);
  assign prod_i    = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.gain_i}) * PROD_W'(err);
  assign prod_m    = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.gain_m}) * PROD_W'(err);

  // Stage 1: product register
  logic signed [PROD_W-1:0] s1_prod_p_q, s1_prod_i_q, s1_prod_m_q;
  logic                     s1_neg_q, s1_band_q;
  logic signed [TEMP_W-1:0] s1_temp_q;

  // Controller state
  logic signed [STATE_W-1:0] integ_q, integ_d, integ_base;
  logic signed [STATE_W-1:0] hsum_q, hsum_d;
  logic signed [STATE_W-1:0] hist_q [HISTORY_DEPTH];
  logic signed [STATE_W-1:0] p_ext, i_ext, m_ext, prop, integ_lim;
  logic signed [STATE_W-1:0] total_d;

  assign p_ext     = {{(STATE_W-PROD_W){s1_prod_p_q[PROD_W-1]}}, s1_prod_p_q};
  assign i_ext     = {{(STATE_W-PROD_W){s1_prod_i_q[PROD_W-1]}}, s1_prod_i_q};
  assign m_ext     = {{(STATE_W-PROD_W){s1_prod_m_q[PROD_W-1]}}, s1_prod_m_q};
  assign integ_lim = $signed({{(STATE_W-LIMIT_W){1'b0}}, cfg.max_integral});

  always_comb begin
    if (s1_neg_q) begin
      integ_base = i_ext;
    end else if (s1_band_q) begin
      integ_base = integ_q + i_ext;
    end else begin
      integ_base = integ_q;
    end
    integ_d = (integ_base > integ_lim) ? integ_lim : integ_base;
    prop    = s1_neg_q ? '0 : p_ext;
    // running sum: add the newest entry, drop the oldest
    hsum_d  = hsum_q + m_ext - hist_q[HISTORY_DEPTH-1];
    total_d = prop + integ_d + hsum_d;
  end

  // Stage 2: total register
  logic signed [STATE_W-1:0] s2_total_q;
  logic signed [TEMP_W-1:0]  s2_temp_q;

  // Result register
  logic [DUTY_W-1:0]         out_duty_q;
  logic signed [TEMP_W-1:0]  out_temp_q;

  assign duty_percent_o  = out_duty_q;
  assign measured_temp_o = out_temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en0) begin
        s0_valid_q <= in_valid_i;
      end
      if (en1) begin
        s1_valid_q <= s0_valid_q;
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (en3) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      s0_temp_q <= temperature_tenths_i;
    end
    if (en1 && s0_valid_q) begin
      s1_prod_p_q <= prod_p;
      s1_prod_i_q <= prod_i;
      s1_prod_m_q <= prod_m;
      s1_neg_q    <= err_neg;
      s1_band_q   <= in_band;
      s1_temp_q   <= s0_temp_q;
    end
    if (s1_fire) begin
      s2_total_q <= total_d;
      s2_temp_q  <= s1_temp_q;
    end
    if (en3 && s2_valid_q) begin
      out_duty_q <= duty_from_total(s2_total_q);
      out_temp_q <= s2_temp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      hsum_q  <= '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_q[k] <= '0;
      end
    end else if (s1_fire) begin
      integ_q <= integ_d;
      hsum_q  <= hsum_d;
      for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
        hist_q[k] <= hist_q[k-1];
      end
      hist_q[0] <= m_ext;
    end
  end

  `ASSERT_DEFAULT(duty_in_range_a, out_valid_o |-> (duty_percent_o <= DUTY_MAX), "duty high")
  `ASSERT_DEFAULT(stall_full_a, in_stall_o |-> (s0_valid_q && s1_valid_q && s2_valid_q), "stall")
  `ASSERT_DEFAULT(integ_limited_a, s1_fire |=> (integ_q <= $past(integ_lim)), "windup")

endmodule
